### hdl/fat_cluster_table_engine_unit_defines.svh
// assertion macros for the fat cluster table engine
// no dependencies; included by the files that carry assertions
`ifndef FAT_CLUSTER_TABLE_ENGINE_UNIT_DEFINES_SVH
`define FAT_CLUSTER_TABLE_ENGINE_UNIT_DEFINES_SVH

// condition holds in the same cycle
`define FCT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fct assertion failed");

// condition holds in the following cycle
`define FCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fct assertion failed");

`endif

### hdl/fct_pkg.sv
// shared types, constants and helper functions of the fat cluster table engine
// no dependencies
package fct_pkg;

   localparam int TABLE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int ENTRY_W     = 28;
   localparam int TOTAL_W     = 12;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 12;

   localparam logic [ENTRY_W-1:0] MASK16      = 28'h000FFFF;
   localparam logic [ENTRY_W-1:0] MASK28      = 28'hFFFFFFF;
   localparam logic [ENTRY_W-1:0] EOC16_LIMIT = 28'h000FFF8;
   localparam logic [ENTRY_W-1:0] EOC32_LIMIT = 28'hFFFFFF8;
   localparam logic [ENTRY_W-1:0] EOC16_MARK  = 28'h000FFFF;
   localparam logic [ENTRY_W-1:0] EOC32_MARK  = 28'hFFFFFFF;
   localparam logic [ADDR_W-1:0]  HINT_MAX    = ADDR_W'(TABLE_DEPTH - 1);
   localparam logic [ADDR_W-1:0]  FIRST_DATA  = ADDR_W'(2);

   // request kinds
   localparam logic [1:0] KIND_READ  = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_ALLOC = 2'd2;
   localparam logic [1:0] KIND_FREE  = 2'd3;

   // fault codes
   localparam logic [1:0] FAULT_NONE  = 2'd0;
   localparam logic [1:0] FAULT_RANGE = 2'd1;
   localparam logic [1:0] FAULT_CHAIN = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOTAL = 1'b1;

   typedef struct packed {
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      logic [ENTRY_W-1:0] wr_data;
      logic               rd_en;
      logic [ADDR_W-1:0]  rd_addr;
   } fct_mem_req_type;

   function automatic logic [ENTRY_W-1:0] mode_mask(input logic wide);
      return wide ? MASK28 : MASK16;
   endfunction

   function automatic logic is_eoc(input logic [ENTRY_W-1:0] v, input logic wide);
      return wide ? (v >= EOC32_LIMIT) : (v >= EOC16_LIMIT);
   endfunction

   // cluster number carries one extra top bit that flags a link beyond the table
   function automatic logic in_range(input logic [ADDR_W:0] c,
                                     input logic [TOTAL_W-1:0] total);
      logic [ADDR_W:0] top;
      top = (ADDR_W+1)'(total) + (ADDR_W+1)'(1);
      return !c[ADDR_W] && (c[ADDR_W-1:0] >= FIRST_DATA) && (c <= top);
   endfunction

endpackage

### hdl/fct_req_if.sv
// request channel of the fat cluster table engine
// depends on fct_pkg
interface fct_req_if;
   logic                         valid;
   logic                         ready;
   logic [1:0]                   kind;
   logic [fct_pkg::ADDR_W-1:0]   cluster;
   logic [fct_pkg::ENTRY_W-1:0]  entry_value;

   modport source (output valid, output kind, output cluster, output entry_value,
                   input ready);
   modport sink (input valid, input kind, input cluster, input entry_value,
                 output ready);
endinterface

### hdl/fct_rsp_if.sv
// response channel of the fat cluster table engine
// depends on fct_pkg
interface fct_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [fct_pkg::ENTRY_W-1:0]  read_value;
   logic                         end_of_chain;
   logic [fct_pkg::ADDR_W-1:0]   new_cluster;
   logic [1:0]                   fault;

   modport source (output valid, output read_value, output end_of_chain,
                   output new_cluster, output fault, input ready);
   modport sink (input valid, input read_value, input end_of_chain,
                 input new_cluster, input fault, output ready);
endinterface

### hdl/fct_table_ram.sv
// cluster table storage: one write port, one registered read port
// depends on fct_pkg
module fct_table_ram (
   input  logic                          clock,
   input  fct_pkg::fct_mem_req_type      mem_req,
   output logic [fct_pkg::ENTRY_W-1:0]   rd_data_ff
);

   logic [fct_pkg::ENTRY_W-1:0] table_mem_ff [fct_pkg::TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         table_mem_ff[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= table_mem_ff[mem_req.rd_addr];
      end
   end

endmodule

### hdl/fat_cluster_table_engine_unit.sv
// FAT cluster table engine: after reset the table is swept to zero, one entry per
// cycle, with req ready low. An in-range read or write goes to the table in the
// accepting cycle; an allocate reads and tests entries in turn until it finds a free
// one or runs off the table, a chain free reads and zeroes one link at a time until
// an end mark or a fault; a response still held by the sink holds the engine in its
// done state. Every step uses the table's one write port and its registered read port.
// depends on fct_pkg, fct_req_if, fct_rsp_if, fct_table_ram and the defines header
`include "fat_cluster_table_engine_unit_defines.svh"

module fat_cluster_table_engine_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   fct_req_if.sink                              req_chan,
   fct_rsp_if.source                            rsp_chan,
   input  logic                                 csr_wr_en,
   input  logic [fct_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [fct_pkg::CSR_DATA_W-1:0]       csr_wr_data
);

   localparam int AW = fct_pkg::ADDR_W;
   localparam int EW = fct_pkg::ENTRY_W;
   localparam int TW = fct_pkg::TOTAL_W;

   localparam logic [2:0] ST_CLEAR     = 3'd0;
   localparam logic [2:0] ST_IDLE      = 3'd1;
   localparam logic [2:0] ST_RD_WAIT   = 3'd2;
   localparam logic [2:0] ST_SCAN      = 3'd3;
   localparam logic [2:0] ST_SCAN_WAIT = 3'd4;
   localparam logic [2:0] ST_WALK      = 3'd5;
   localparam logic [2:0] ST_WALK_WAIT = 3'd6;
   localparam logic [2:0] ST_DONE      = 3'd7;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [AW:0]   c_ff, c_in;
   logic [TW-1:0] count_ff, count_in;
   logic [AW-1:0] hint_ff, hint_in;
   logic          wide_ff;
   logic [TW-1:0] total_ff;

   logic [EW-1:0] res_read_ff, res_read_in;
   logic          res_eoc_ff, res_eoc_in;
   logic [AW-1:0] res_new_ff, res_new_in;
   logic [1:0]    res_fault_ff, res_fault_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [EW-1:0] rsp_read_ff;
   logic          rsp_eoc_ff;
   logic [AW-1:0] rsp_new_ff;
   logic [1:0]    rsp_fault_ff;
   logic          rsp_load;

   fct_pkg::fct_mem_req_type mem_req;
   logic [EW-1:0] rd_data_ff;
   logic [EW-1:0] mask;
   logic [EW-1:0] entry;
   logic          req_accept;

   fct_table_ram u_table (
      .clock      (clock),
      .mem_req    (mem_req),
      .rd_data_ff (rd_data_ff)
   );

   assign mask       = fct_pkg::mode_mask(wide_ff);
   assign entry      = rd_data_ff & mask;
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_accept = req_chan.valid && req_chan.ready;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      c_in         = c_ff;
      count_in     = count_ff;
      hint_in      = hint_ff;
      res_read_in  = res_read_ff;
      res_eoc_in   = res_eoc_ff;
      res_new_in   = res_new_ff;
      res_fault_in = res_fault_ff;
      rsp_load     = 1'b0;
      mem_req      = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = clr_ff;
            clr_in          = clr_ff + AW'(1);
            if (clr_ff == fct_pkg::HINT_MAX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               c_in         = {1'b0, req_chan.cluster};
               count_in     = '0;
               res_read_in  = '0;
               res_eoc_in   = 1'b0;
               res_new_in   = '0;
               res_fault_in = fct_pkg::FAULT_NONE;
               case (req_chan.kind)
                  fct_pkg::KIND_READ: begin
                     if (fct_pkg::in_range({1'b0, req_chan.cluster}, total_ff)) begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = req_chan.cluster;
                        state_in        = ST_RD_WAIT;
                     end else begin
                        res_fault_in = fct_pkg::FAULT_RANGE;
                        state_in     = ST_DONE;
                     end
                  end
                  fct_pkg::KIND_WRITE: begin
                     if (fct_pkg::in_range({1'b0, req_chan.cluster}, total_ff)) begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = req_chan.cluster;
                        mem_req.wr_data = req_chan.entry_value & mask;
                     end else begin
                        res_fault_in = fct_pkg::FAULT_RANGE;
                     end
                     state_in = ST_DONE;
                  end
                  fct_pkg::KIND_ALLOC: begin
                     c_in     = (hint_ff < fct_pkg::FIRST_DATA) ?
                                {1'b0, fct_pkg::FIRST_DATA} : {1'b0, hint_ff};
                     state_in = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_WALK;
                  end
               endcase
            end
         end
         ST_RD_WAIT: begin
            res_read_in = entry;
            res_eoc_in  = fct_pkg::is_eoc(entry, wide_ff);
            state_in    = ST_DONE;
         end
         ST_SCAN: begin
            if (fct_pkg::in_range(c_ff, total_ff)) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = c_ff[AW-1:0];
               state_in        = ST_SCAN_WAIT;
            end else begin
               // table full: nothing found, no fault
               state_in = ST_DONE;
            end
         end
         ST_SCAN_WAIT: begin
            if (entry == '0) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = c_ff[AW-1:0];
               mem_req.wr_data = wide_ff ? fct_pkg::EOC32_MARK : fct_pkg::EOC16_MARK;
               res_new_in      = c_ff[AW-1:0];
               hint_in         = (c_ff[AW-1:0] == fct_pkg::HINT_MAX) ?
                                 fct_pkg::HINT_MAX : c_ff[AW-1:0] + AW'(1);
               state_in        = ST_DONE;
            end else begin
               c_in     = c_ff + (AW+1)'(1);
               state_in = ST_SCAN;
            end
         end
         ST_WALK: begin
            if (!fct_pkg::in_range(c_ff, total_ff)) begin
               res_fault_in = fct_pkg::FAULT_RANGE;
               state_in     = ST_DONE;
            end else if (count_ff >= total_ff) begin
               res_fault_in = fct_pkg::FAULT_CHAIN;
               state_in     = ST_DONE;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = c_ff[AW-1:0];
               state_in        = ST_WALK_WAIT;
            end
         end
         ST_WALK_WAIT: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = c_ff[AW-1:0];
            if (c_ff[AW-1:0] < hint_ff) begin
               hint_in = c_ff[AW-1:0];
            end
            count_in = count_ff + TW'(1);
            if (fct_pkg::is_eoc(entry, wide_ff)) begin
               state_in = ST_DONE;
            end else begin
               // any link bit above the table folds into the out-of-table flag
               c_in     = {|entry[EW-1:AW], entry[AW-1:0]};
               state_in = ST_WALK;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         hint_ff      <= fct_pkg::FIRST_DATA;
         rsp_valid_ff <= 1'b0;
         wide_ff      <= 1'b0;
         total_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         hint_ff      <= hint_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            case (csr_index)
               fct_pkg::CSR_WIDE:  wide_ff  <= csr_wr_data[0];
               fct_pkg::CSR_TOTAL: total_ff <= csr_wr_data[TW-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      c_ff         <= c_in;
      count_ff     <= count_in;
      res_read_ff  <= res_read_in;
      res_eoc_ff   <= res_eoc_in;
      res_new_ff   <= res_new_in;
      res_fault_ff <= res_fault_in;
      if (rsp_load) begin
         rsp_read_ff  <= res_read_ff;
         rsp_eoc_ff   <= res_eoc_ff;
         rsp_new_ff   <= res_new_ff;
         rsp_fault_ff <= res_fault_ff;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.read_value   = rsp_read_ff;
   assign rsp_chan.end_of_chain = rsp_eoc_ff;
   assign rsp_chan.new_cluster  = rsp_new_ff;
   assign rsp_chan.fault        = rsp_fault_ff;

   `FCT_ASSERT_NOW(a_hint_floor, clock, reset, state_ff != ST_CLEAR, hint_ff >= fct_pkg::FIRST_DATA)
   `FCT_ASSERT_NOW(a_walk_count, clock, reset, state_ff == ST_WALK_WAIT, count_ff < total_ff)
   `FCT_ASSERT_NOW(a_scan_in_table, clock, reset, state_ff == ST_SCAN_WAIT, !c_ff[AW])
   `FCT_ASSERT_NEXT(a_done_loads, clock, reset, (state_ff == ST_DONE) && rsp_load, rsp_valid_ff && (state_ff == ST_IDLE))

endmodule

### bench/fat_cluster_table_engine_unit_test.sv
`timescale 1ns / 1ps
// self-checking bench for the fat cluster table engine: directed and random traffic
// checked against a cycle-free model of the table held in a scoreboard class
// depends on fct_pkg, fct_req_if, fct_rsp_if and fat_cluster_table_engine_unit
module fat_cluster_table_engine_unit_test;

   localparam int AW    = fct_pkg::ADDR_W;
   localparam int EW    = fct_pkg::ENTRY_W;
   localparam int TW    = fct_pkg::TOTAL_W;
   localparam int DW    = fct_pkg::CSR_DATA_W;
   localparam int DEPTH = fct_pkg::TABLE_DEPTH;

   typedef struct packed {
      logic [EW-1:0] read_value;
      logic          end_of_chain;
      logic [AW-1:0] new_cluster;
      logic [1:0]    fault;
   } fat_result_type;

   // mirror of the cluster table with its free hint and the registers in force
   class fat_table_scoreboard;
      logic [EW-1:0]      entries [DEPTH];
      int unsigned        hint;
      logic               wide;
      int unsigned        total;
      fat_result_type     awaited [$];
      int unsigned        errors;

      function new();
         foreach (entries[i]) entries[i] = '0;
         hint = 2;
         wide = 1'b0;
         total = 0;
         errors = 0;
      endfunction

      function void set_register(input logic [fct_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [DW-1:0] data);
         if (idx == fct_pkg::CSR_WIDE) begin
            wide = data[0];
         end else begin
            total = 32'(data);
         end
      endfunction

      function int unsigned pending();
         return awaited.size();
      endfunction

      function logic [EW-1:0] mode_bits();
         return wide ? fct_pkg::MASK28 : fct_pkg::MASK16;
      endfunction

      function logic at_chain_end(input logic [EW-1:0] v);
         return wide ? (v >= fct_pkg::EOC32_LIMIT) : (v >= fct_pkg::EOC16_LIMIT);
      endfunction

      function logic cluster_ok(input int unsigned c);
         return c >= 2 && c <= total + 1 && c < DEPTH;
      endfunction

      function void note_request(input logic [1:0] kind, input logic [AW-1:0] cluster,
                                 input logic [EW-1:0] value);
         fat_result_type     res;
         int unsigned        c;
         int unsigned        count;
         logic [EW-1:0]      link;
         logic               done;
         res = '0;
         case (kind)
            fct_pkg::KIND_READ: begin
               if (cluster_ok(32'(cluster))) begin
                  res.read_value = entries[cluster] & mode_bits();
                  res.end_of_chain = at_chain_end(res.read_value);
               end else begin
                  res.fault = fct_pkg::FAULT_RANGE;
               end
            end
            fct_pkg::KIND_WRITE: begin
               if (cluster_ok(32'(cluster))) begin
                  entries[cluster] = value & mode_bits();
               end else begin
                  res.fault = fct_pkg::FAULT_RANGE;
               end
            end
            fct_pkg::KIND_ALLOC: begin
               c = (hint < 2) ? 2 : hint;
               while (cluster_ok(c) && res.new_cluster == '0) begin
                  if ((entries[c] & mode_bits()) == '0) begin
                     entries[c] = wide ? fct_pkg::EOC32_MARK : fct_pkg::EOC16_MARK;
                     res.new_cluster = c[AW-1:0];
                     hint = (c + 1 > DEPTH - 1) ? DEPTH - 1 : c + 1;
                  end
                  c++;
               end
            end
            default: begin
               c = 32'(cluster);
               count = 0;
               done = 1'b0;
               while (!done) begin
                  if (!cluster_ok(c)) begin
                     res.fault = fct_pkg::FAULT_RANGE;
                     done = 1'b1;
                  end else if (count >= total) begin
                     res.fault = fct_pkg::FAULT_CHAIN;
                     done = 1'b1;
                  end else begin
                     link = entries[c] & mode_bits();
                     entries[c] = '0;
                     if (c < hint) hint = c;
                     count++;
                     if (at_chain_end(link)) begin
                        done = 1'b1;
                     end else begin
                        c = 32'(link);
                     end
                  end
               end
            end
         endcase
         awaited.push_back(res);
      endfunction

      task report(input string what, input longint unsigned got, input longint unsigned want);
         errors++;
         // keep the log short once things go badly wrong
         if (errors <= 40)
            $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      endtask

      task check_result(input fat_result_type got);
         fat_result_type want;
         if (awaited.size() == 0) begin
            report("response with no request pending", 64'(got), 64'd0);
            return;
         end
         want = awaited.pop_front();
         if (got.read_value !== want.read_value)
            report("read_value", 64'(got.read_value), 64'(want.read_value));
         if (got.end_of_chain !== want.end_of_chain)
            report("end_of_chain", 64'(got.end_of_chain), 64'(want.end_of_chain));
         if (got.new_cluster !== want.new_cluster)
            report("new_cluster", 64'(got.new_cluster), 64'(want.new_cluster));
         if (got.fault !== want.fault)
            report("fault", 64'(got.fault), 64'(want.fault));
      endtask
   endclass

   logic                                clock = 1'b0;
   logic                                reset;
   logic                                csr_wr_en;
   logic [fct_pkg::CSR_INDEX_W-1:0]     csr_index;
   logic [DW-1:0]                       csr_wr_data;

   fct_req_if req_bus ();
   fct_rsp_if rsp_bus ();

   fat_table_scoreboard sb = new();

   int unsigned items_sent = 0;
   int unsigned burst_left = 0;
   int unsigned stall_left = 0;
   int unsigned calm_left = 0;

   fat_cluster_table_engine_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // responses are checked before the new request is noted in the same cycle
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_result('{rsp_bus.read_value, rsp_bus.end_of_chain,
                           rsp_bus.new_cluster, rsp_bus.fault});
      if (!reset && req_bus.valid && req_bus.ready)
         sb.note_request(req_bus.kind, req_bus.cluster, req_bus.entry_value);
   end

   // response side: short random stalls with calm stretches in between
   always @(negedge clock) begin
      if (stall_left != 0) begin
         rsp_bus.ready = 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready = 1'b1;
         if (calm_left != 0) begin
            calm_left--;
         end else if ($urandom_range(0, 40) == 0) begin
            calm_left = $urandom_range(20, 150);
         end else if ($urandom_range(0, 2) == 0) begin
            stall_left = $urandom_range(1, 7);
         end
      end
   end

   // one request transaction, then a random gap when the burst runs out
   task automatic send(input logic [1:0] kind, input logic [AW-1:0] cluster,
                       input logic [EW-1:0] value);
      int unsigned gap;
      req_bus.valid = 1'b1;
      req_bus.kind = kind;
      req_bus.cluster = cluster;
      req_bus.entry_value = value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0) begin
            req_bus.valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic write_register(input logic [fct_pkg::CSR_INDEX_W-1:0] idx,
                                 input logic [DW-1:0] data);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wr_data = data;
      @(negedge clock);
      csr_wr_en = 1'b0;
      sb.set_register(idx, data);
   endtask

   // drain every outstanding transaction so the block is idle
   task automatic settle();
      req_bus.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   function automatic logic [AW-1:0] pick_cluster();
      int unsigned top;
      top = sb.total + 1;
      if (top > DEPTH - 1) top = DEPTH - 1;
      if (top < 2 || $urandom_range(0, 6) == 0) return AW'($urandom_range(0, DEPTH - 1));
      return AW'($urandom_range(2, top));
   endfunction

   function automatic logic [EW-1:0] end_mark_value();
      if (sb.wide) return fct_pkg::EOC32_LIMIT | EW'($urandom_range(0, 7));
      // junk above bit 15 is dropped by the write in narrow mode
      return (EW'($urandom) & ~fct_pkg::MASK16) | fct_pkg::EOC16_LIMIT |
             EW'($urandom_range(0, 7));
   endfunction

   function automatic logic [EW-1:0] pick_value();
      case ($urandom_range(0, 5))
         0, 1: return EW'(pick_cluster());
         2: return end_mark_value();
         3: return '0;
         4: return EW'($urandom);
         default: return EW'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   // well-formed chain: link a few clusters, close it with an end mark, free it
   task automatic free_built_chain();
      logic [AW-1:0] links [$];
      int unsigned   len;
      len = $urandom_range(1, 6);
      repeat (len) links.push_back(pick_cluster());
      for (int i = 0; i < len; i++) begin
         if (i == len - 1) begin
            send(fct_pkg::KIND_WRITE, links[i], end_mark_value());
         end else begin
            send(fct_pkg::KIND_WRITE, links[i], EW'(links[i + 1]));
         end
      end
      send(fct_pkg::KIND_FREE, links[0], EW'($urandom));
   endtask

   task automatic random_item();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 22) begin
         send(fct_pkg::KIND_READ, pick_cluster(), EW'($urandom));
      end else if (sel < 42) begin
         send(fct_pkg::KIND_WRITE, pick_cluster(), pick_value());
      end else if (sel < 67) begin
         send(fct_pkg::KIND_ALLOC, AW'($urandom), EW'($urandom));
      end else if (sel < 77) begin
         free_built_chain();
      end else if (sel < 87) begin
         send(fct_pkg::KIND_FREE, pick_cluster(), EW'($urandom));
      end else begin
         send(2'($urandom), AW'($urandom), EW'($urandom));
      end
   endtask

   initial begin
      logic              wide_sel;
      logic [TW-1:0]     total_sel;
      int unsigned       stop_at;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = fct_pkg::CSR_WIDE;
      csr_wr_data = '0;
      req_bus.valid = 1'b0;
      req_bus.kind = fct_pkg::KIND_READ;
      req_bus.cluster = '0;
      req_bus.entry_value = '0;
      rsp_bus.ready = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // no data clusters at all
      write_register(fct_pkg::CSR_WIDE, '0);
      write_register(fct_pkg::CSR_TOTAL, '0);
      send(fct_pkg::KIND_READ, AW'(2), '0);
      send(fct_pkg::KIND_ALLOC, '0, '0);
      send(fct_pkg::KIND_FREE, AW'(2), '0);
      settle();

      write_register(fct_pkg::CSR_TOTAL, DW'(20));
      send(fct_pkg::KIND_READ, AW'(0), '0);
      send(fct_pkg::KIND_READ, AW'(21), '0);
      send(fct_pkg::KIND_READ, AW'(22), '0);
      send(fct_pkg::KIND_WRITE, AW'(4095), 28'h1234567);
      send(fct_pkg::KIND_WRITE, AW'(2), 28'hFFFFFFF);
      send(fct_pkg::KIND_READ, AW'(2), '0);
      send(fct_pkg::KIND_WRITE, AW'(3), 28'h000FFF7);
      send(fct_pkg::KIND_READ, AW'(3), '0);
      send(fct_pkg::KIND_ALLOC, '0, '0);
      send(fct_pkg::KIND_WRITE, AW'(5), EW'(6));
      send(fct_pkg::KIND_WRITE, AW'(6), EW'(7));
      send(fct_pkg::KIND_WRITE, AW'(7), fct_pkg::EOC16_LIMIT);
      send(fct_pkg::KIND_FREE, AW'(5), '0);
      // link past the last cluster, then a zero link
      send(fct_pkg::KIND_WRITE, AW'(9), 28'h30);
      send(fct_pkg::KIND_FREE, AW'(9), '0);
      send(fct_pkg::KIND_FREE, AW'(10), '0);
      // two-entry loop: the second visit finds a link already zeroed
      send(fct_pkg::KIND_WRITE, AW'(11), EW'(12));
      send(fct_pkg::KIND_WRITE, AW'(12), EW'(11));
      send(fct_pkg::KIND_FREE, AW'(11), '0);
      send(fct_pkg::KIND_FREE, AW'(1), '0);
      send(fct_pkg::KIND_ALLOC, '0, '0);
      settle();

      // single cluster: full table, then wide mode over narrow entries
      write_register(fct_pkg::CSR_TOTAL, DW'(1));
      send(fct_pkg::KIND_ALLOC, '0, '0);
      send(fct_pkg::KIND_FREE, AW'(2), '0);
      send(fct_pkg::KIND_ALLOC, '0, '0);
      settle();
      write_register(fct_pkg::CSR_WIDE, DW'(1));
      send(fct_pkg::KIND_READ, AW'(2), '0);
      send(fct_pkg::KIND_WRITE, AW'(2), fct_pkg::EOC32_LIMIT);
      send(fct_pkg::KIND_READ, AW'(2), '0);

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: begin wide_sel = 1'b1; total_sel = TW'(12); end
            1: begin wide_sel = 1'b1; total_sel = TW'(DEPTH - 2); end
            2: begin wide_sel = 1'b0; total_sel = TW'(30); end
            3: begin wide_sel = 1'b0; total_sel = TW'(1); end
            4: begin wide_sel = 1'b1; total_sel = TW'(64); end
            5: begin wide_sel = 1'b0; total_sel = TW'(DEPTH - 2); end
            6: begin
               wide_sel = 1'($urandom_range(0, 1));
               total_sel = TW'($urandom_range(2, 300));
            end
            default: begin
               wide_sel = 1'($urandom_range(0, 1));
               total_sel = TW'($urandom_range(0, DEPTH - 2));
            end
         endcase
         settle();
         write_register(fct_pkg::CSR_WIDE, DW'(wide_sel));
         write_register(fct_pkg::CSR_TOTAL, DW'(total_sel));
         stop_at = items_sent + 230;
         while (items_sent < stop_at) random_item();
      end

      settle();
      repeat (30) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #(2_000_000_000);
      $display("Verification failed");
      $finish;
   end

endmodule
